### sv/lrast_pkg.sv
// shared types and constants for the line rasterizer step block
package lrast_pkg;

	// octant reflection applied on load
	typedef enum logic [1:0] {
		OCT_DIRECT  = 2'd0,
		OCT_NEG_X   = 2'd1,
		OCT_REFLECT = 2'd2,
		OCT_NEG_Y   = 2'd3
	} octant_t;

	// line control state passed between setup, step and the state registers
	typedef struct packed {
		octant_t octant;
		logic    swapped;
		logic    active;
	} line_ctrl_t;

	// request kinds carried on s_tuser
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_STEP = 1'b1;

	// configuration port
	localparam int   APB_ADDR_BITS    = 3;
	localparam logic REG_LINE_WIDTH   = 1'b0;
	localparam logic [1:0] LINE_WIDTH_RESET = 2'd1;
	localparam logic [1:0] LINE_WIDTH_THICK = 2'd2;

endpackage

### sv/lrast_cfg.sv
// apb register file holding the line width setting
module lrast_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [lrast_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	output logic [1:0]                           line_width
);
	import lrast_pkg::*;

	logic [1:0] line_width_q;
	logic       wr_en;
	logic       reg_sel;

	// register index is the word address
	assign reg_sel = paddr[2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready && (reg_sel == REG_LINE_WIDTH);

	// line width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RESET;
		end else if (wr_en) begin
			line_width_q <= pwdata[1:0];
		end
	end

	// read back
	assign prdata     = (reg_sel == REG_LINE_WIDTH) ? {30'd0, line_width_q} : 32'd0;
	assign line_width = line_width_q;

endmodule

### sv/lrast_setup.sv
// load logic: octant reflection, axis swap and initial decision value
module lrast_setup #(
	parameter int COORD_BITS = 10
) (
	input  logic [COORD_BITS-1:0]        start_x,
	input  logic [COORD_BITS-1:0]        start_y,
	input  logic [COORD_BITS-1:0]        end_x,
	input  logic [COORD_BITS-1:0]        end_y,
	output lrast_pkg::line_ctrl_t        ctrl,
	output logic signed [COORD_BITS+1:0] run_pos,
	output logic signed [COORD_BITS+1:0] cross_pos,
	output logic signed [COORD_BITS+1:0] run_end,
	output logic signed [COORD_BITS+2:0] decision,
	output logic [COORD_BITS:0]          major,
	output logic [COORD_BITS:0]          minor
);
	import lrast_pkg::*;

	localparam int W = COORD_BITS + 2;

	logic signed [W-1:0] sxe, sye, exe, eye;
	logic signed [W-1:0] ax, ay, bx, by;
	logic signed [W-1:0] dx0, dy0, dx, dy;
	octant_t             oct;
	logic                swap;

	assign sxe = signed'({2'b00, start_x});
	assign sye = signed'({2'b00, start_y});
	assign exe = signed'({2'b00, end_x});
	assign eye = signed'({2'b00, end_y});

	// reflect the endpoints into the first quadrant
	always_comb begin
		if (end_x <= start_x && end_y >= start_y) begin
			oct = OCT_NEG_X;
			ax = -sxe; ay = sye; bx = -exe; by = eye;
		end else if (end_x <= start_x && end_y <= start_y) begin
			oct = OCT_REFLECT;
			ax = -sye; ay = -sxe; bx = -eye; by = -exe;
		end else if (end_x >= start_x && start_y >= end_y) begin
			oct = OCT_NEG_Y;
			ax = sxe; ay = -sye; bx = exe; by = -eye;
		end else begin
			oct = OCT_DIRECT;
			ax = sxe; ay = sye; bx = exe; by = eye;
		end
	end

	// swap axes when steep
	assign dx0  = bx - ax;
	assign dy0  = by - ay;
	assign swap = dy0 > dx0;
	assign dx   = swap ? dy0 : dx0;
	assign dy   = swap ? dx0 : dy0;

	assign run_pos   = swap ? ay : ax;
	assign cross_pos = swap ? ax : ay;
	assign run_end   = swap ? by : bx;

	// both deltas are non-negative here
	assign major = dx[COORD_BITS:0];
	assign minor = dy[COORD_BITS:0];

	// decision starts at dy - dx/2
	assign decision = signed'({2'b00, minor}) - signed'({3'b000, major[COORD_BITS:1]});

	assign ctrl.octant  = oct;
	assign ctrl.swapped = swap;
	assign ctrl.active  = run_pos < run_end;

endmodule

### sv/lrast_step.sv
// step logic: decision update and mapping back to screen space
module lrast_step #(
	parameter int COORD_BITS = 10
) (
	input  lrast_pkg::line_ctrl_t        ctrl,
	input  logic signed [COORD_BITS+1:0] run_pos,
	input  logic signed [COORD_BITS+1:0] cross_pos,
	input  logic signed [COORD_BITS+1:0] run_end,
	input  logic signed [COORD_BITS+2:0] decision,
	input  logic [COORD_BITS:0]          major,
	input  logic [COORD_BITS:0]          minor,
	input  logic                         thick_en,
	output logic signed [COORD_BITS+1:0] run_pos_n,
	output logic signed [COORD_BITS+1:0] cross_pos_n,
	output logic signed [COORD_BITS+2:0] decision_n,
	output logic                         last_pixel,
	output logic [COORD_BITS-1:0]        pixel_x,
	output logic [COORD_BITS-1:0]        pixel_y,
	output logic                         thick_valid,
	output logic [COORD_BITS-1:0]        thick_x,
	output logic signed [COORD_BITS+1:0] thick_y
);
	import lrast_pkg::*;

	localparam int W = COORD_BITS + 2;
	localparam int D = COORD_BITS + 3;

	logic signed [D-1:0] minor_e, major_e;
	logic signed [W-1:0] px, py, sxp, syp, ty;

	assign minor_e = signed'({2'b00, minor});
	assign major_e = signed'({2'b00, major});

	// midpoint decision update
	assign run_pos_n = run_pos + W'(1);
	always_comb begin
		if (decision < 0) begin
			decision_n  = decision + minor_e;
			cross_pos_n = cross_pos;
		end else begin
			decision_n  = decision + minor_e - major_e;
			cross_pos_n = cross_pos + W'(1);
		end
	end

	// undo the axis swap
	assign px = ctrl.swapped ? cross_pos_n : run_pos_n;
	assign py = ctrl.swapped ? run_pos_n : cross_pos_n;

	// undo the octant reflection, extra pixel one row off
	always_comb begin
		case (ctrl.octant)
			OCT_NEG_X: begin
				sxp = -px; syp = py;  ty = py - W'(1);
			end
			OCT_REFLECT: begin
				sxp = -py; syp = -px; ty = -px - W'(1);
			end
			OCT_NEG_Y: begin
				sxp = px;  syp = -py; ty = -py - W'(1);
			end
			default: begin
				sxp = px;  syp = py;  ty = py + W'(1);
			end
		endcase
	end

	assign last_pixel  = run_pos_n >= run_end;
	assign pixel_x     = sxp[COORD_BITS-1:0];
	assign pixel_y     = syp[COORD_BITS-1:0];
	assign thick_valid = thick_en;
	assign thick_x     = thick_en ? sxp[COORD_BITS-1:0] : '0;
	assign thick_y     = thick_en ? ty : '0;

endmodule

### sv/line_rasterizer_step.sv
// top level of the midpoint line rasterizer step block
//
// Midpoint line rasterizer. A load request (s_tuser = 0) latches two endpoints and
// produces no output; each step request (s_tuser = 1) then emits one pixel of the line,
// the start point excluded and the end point flagged on m_tlast, after which the block
// idles and steps produce nothing until the next load. One request is taken every clock
// unless a step waits on a full result register that m_tready holds back: a request sits
// in the input register while the decision update and screen mapping run, and its pixel
// is written to the output register when it advances. The decision add and compare loop
// in the step logic sets that rate. With line_width set to 2 (APB address 0) each pixel
// carries a second pixel one row above or below, flagged on m_tuser.
module line_rasterizer_step #(
	parameter int COORD_BITS = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// slave request stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// start_x, start_y, end_x, end_y, from the lowest bit up, zero padded
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]    s_tdata,
	// mode
	input  logic                                 s_tuser,
	// master pixel stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// pixel_x, pixel_y, thick_x, thick_y, from the lowest bit up, zero padded
	output logic [((4*COORD_BITS+2+7)/8)*8-1:0]  m_tdata,
	// thick_valid
	output logic                                 m_tuser,
	// last_pixel
	output logic                                 m_tlast,
	// configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [lrast_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);
	import lrast_pkg::*;

	localparam int CB            = COORD_BITS;
	localparam int W             = COORD_BITS + 2;
	localparam int D             = COORD_BITS + 3;
	localparam int OUT_DATA_BITS = ((4*COORD_BITS+2+7)/8)*8;

	logic [1:0] line_width;

	// input register
	logic          valid_s1;
	logic          mode_s1;
	logic [CB-1:0] sx_s1, sy_s1, ex_s1, ey_s1;

	// line state
	line_ctrl_t          ctrl_q;
	logic signed [W-1:0] run_pos_q, cross_pos_q, run_end_q;
	logic signed [D-1:0] decision_q;
	logic [CB:0]         major_q, minor_q;

	// result register
	logic                valid_s2;
	logic [CB-1:0]       pixel_x_s2, pixel_y_s2, thick_x_s2;
	logic signed [W-1:0] thick_y_s2;
	logic                thick_valid_s2, last_s2;

	// setup outputs
	line_ctrl_t          ld_ctrl;
	logic signed [W-1:0] ld_run, ld_cross, ld_end;
	logic signed [D-1:0] ld_dec;
	logic [CB:0]         ld_major, ld_minor;

	// step outputs
	logic signed [W-1:0] st_run, st_cross;
	logic signed [D-1:0] st_dec;
	logic                st_last, st_thick_valid;
	logic [CB-1:0]       st_px, st_py, st_tx;
	logic signed [W-1:0] st_ty;

	logic step_s1, out_free, advance, s_acc;

	lrast_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.line_width (line_width)
	);

	lrast_setup #(.COORD_BITS(COORD_BITS)) u_setup (
		.start_x   (sx_s1),
		.start_y   (sy_s1),
		.end_x     (ex_s1),
		.end_y     (ey_s1),
		.ctrl      (ld_ctrl),
		.run_pos   (ld_run),
		.cross_pos (ld_cross),
		.run_end   (ld_end),
		.decision  (ld_dec),
		.major     (ld_major),
		.minor     (ld_minor)
	);

	lrast_step #(.COORD_BITS(COORD_BITS)) u_step (
		.ctrl        (ctrl_q),
		.run_pos     (run_pos_q),
		.cross_pos   (cross_pos_q),
		.run_end     (run_end_q),
		.decision    (decision_q),
		.major       (major_q),
		.minor       (minor_q),
		.thick_en    (line_width == LINE_WIDTH_THICK),
		.run_pos_n   (st_run),
		.cross_pos_n (st_cross),
		.decision_n  (st_dec),
		.last_pixel  (st_last),
		.pixel_x     (st_px),
		.pixel_y     (st_py),
		.thick_valid (st_thick_valid),
		.thick_x     (st_tx),
		.thick_y     (st_ty)
	);

	// flow control: only a productive step waits for the result register
	assign step_s1  = valid_s1 && (mode_s1 == MODE_STEP) && ctrl_q.active;
	assign out_free = !valid_s2 || m_tready;
	assign advance  = valid_s1 && (!step_s1 || out_free);
	assign s_tready = !valid_s1 || advance;
	assign s_acc    = s_tvalid && s_tready;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			mode_s1 <= s_tuser;
			sx_s1   <= s_tdata[CB-1:0];
			sy_s1   <= s_tdata[2*CB-1:CB];
			ex_s1   <= s_tdata[3*CB-1:2*CB];
			ey_s1   <= s_tdata[4*CB-1:3*CB];
		end
	end

	// line state update on load or productive step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= '{octant: OCT_DIRECT, swapped: 1'b0, active: 1'b0};
			run_pos_q   <= '0;
			cross_pos_q <= '0;
			run_end_q   <= '0;
			decision_q  <= '0;
			major_q     <= '0;
			minor_q     <= '0;
		end else if (advance && (mode_s1 == MODE_LOAD)) begin
			ctrl_q      <= ld_ctrl;
			run_pos_q   <= ld_run;
			cross_pos_q <= ld_cross;
			run_end_q   <= ld_end;
			decision_q  <= ld_dec;
			major_q     <= ld_major;
			minor_q     <= ld_minor;
		end else if (advance && step_s1) begin
			ctrl_q.active <= !st_last;
			run_pos_q     <= st_run;
			cross_pos_q   <= st_cross;
			decision_q    <= st_dec;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && step_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance && step_s1) begin
			pixel_x_s2     <= st_px;
			pixel_y_s2     <= st_py;
			thick_valid_s2 <= st_thick_valid;
			thick_x_s2     <= st_tx;
			thick_y_s2     <= st_ty;
			last_s2        <= st_last;
		end
	end

	// output packing
	assign m_tvalid = valid_s2;
	assign m_tdata  = OUT_DATA_BITS'({thick_y_s2, thick_x_s2, pixel_y_s2, pixel_x_s2});
	assign m_tuser  = thick_valid_s2;
	assign m_tlast  = last_s2;

	// an active line has not yet reached its end
	a_active_before_end: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_q.active |-> (run_pos_q < run_end_q))
		else $error("active line past its end point");

	// the last pixel ends the line
	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_s1 && st_last) |=> !ctrl_q.active)
		else $error("line still active after last pixel");

	// a productive step always lands in the result register
	a_step_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_s1) |=> m_tvalid)
		else $error("step result lost");

	// stall only when a step waits on a full, blocked result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (step_s1 && m_tvalid && !m_tready))
		else $error("input stalled without cause");

	// without the extra pixel its fields are zero
	a_thin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> ((thick_x_s2 == '0) && (thick_y_s2 == '0)))
		else $error("extra pixel fields set at width one");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for line_rasterizer_step: directed table, then random line sequences
module testbench;
	import lrast_pkg::*;

	localparam int COORD_BITS = 10;
	localparam int COORD_MAX = (1 << COORD_BITS) - 1;
	localparam int IN_BITS = ((4*COORD_BITS+7)/8)*8;
	localparam int OUT_BITS = ((4*COORD_BITS+2+7)/8)*8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS = 260;
	localparam int DIR_ROWS = 25;
	localparam int NUM_PHASES = 5;
	localparam logic [APB_ADDR_BITS-1:0] WIDTH_ADDR = APB_ADDR_BITS'(4 * int'(REG_LINE_WIDTH));

	// one plotted pixel as it leaves the block
	typedef struct packed {
		logic [9:0]  pixel_x;
		logic [9:0]  pixel_y;
		logic        thick_valid;
		logic [9:0]  thick_x;
		logic [11:0] thick_y;
		logic        last_pixel;
	} pixel_t;

	// directed row: optional width write, one request, optional hand-typed result
	typedef struct packed {
		logic       cfg;
		logic [1:0] width;
		logic       mode;
		logic [9:0] sx;
		logic [9:0] sy;
		logic [9:0] ex;
		logic [9:0] ey;
		logic       typed;
		logic       has_pix;
		pixel_t     pix;
	} dir_row_t;

	localparam pixel_t NO_PIX = '0;
	localparam dir_row_t STEP_ROW = '{0, 0, MODE_STEP, 0, 0, 0, 0, 0, 0, NO_PIX};
	localparam dir_row_t IDLE_STEP = '{0, 0, MODE_STEP, 0, 0, 0, 0, 1, 0, NO_PIX};

	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		IDLE_STEP,
		'{0, 0, MODE_LOAD, 0, 0, 2, 2, 0, 0, NO_PIX},
		'{0, 0, MODE_STEP, 0, 0, 0, 0, 1, 1, '{1, 1, 0, 0, 0, 0}},
		'{0, 0, MODE_STEP, 0, 0, 0, 0, 1, 1, '{2, 2, 0, 0, 0, 1}},
		IDLE_STEP,
		'{0, 0, MODE_LOAD, 1023, 1023, 1023, 1023, 0, 0, NO_PIX},
		IDLE_STEP,
		'{0, 0, MODE_LOAD, 1023, 0, 0, 1023, 0, 0, NO_PIX},
		STEP_ROW,
		STEP_ROW,
		'{0, 0, MODE_LOAD, 0, 1023, 1023, 0, 0, 0, NO_PIX},
		STEP_ROW,
		'{1, LINE_WIDTH_THICK, MODE_LOAD, 0, 0, 2, 2, 0, 0, NO_PIX},
		'{0, 0, MODE_STEP, 0, 0, 0, 0, 1, 1, '{1, 1, 1, 1, 2, 0}},
		'{0, 0, MODE_STEP, 0, 0, 0, 0, 1, 1, '{2, 2, 1, 2, 3, 1}},
		'{0, 0, MODE_LOAD, 1023, 1023, 0, 0, 0, 0, NO_PIX},
		STEP_ROW,
		'{0, 0, MODE_LOAD, 3, 1, 6, 0, 0, 0, NO_PIX},
		STEP_ROW,
		STEP_ROW,
		STEP_ROW,
		'{0, 0, MODE_LOAD, 100, 200, 101, 300, 0, 0, NO_PIX},
		STEP_ROW,
		'{0, 0, MODE_LOAD, 512, 512, 512, 600, 0, 0, NO_PIX},
		STEP_ROW
	};

	localparam logic [1:0] PHASE_WIDTHS [NUM_PHASES] = '{
		2'd3, 2'd0, LINE_WIDTH_RESET, LINE_WIDTH_THICK, 2'd3
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_BITS-1:0]  s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_BITS-1:0] m_tdata;
	logic                m_tuser;
	logic                m_tlast;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	// predictor state and its copy of the width register
	logic [1:0] rast_width = LINE_WIDTH_RESET;
	octant_t    rast_oct = OCT_DIRECT;
	bit         rast_swapped = 1'b0;
	int         rast_run = 0;
	int         rast_cross = 0;
	int         rast_run_end = 0;
	int         rast_decision = 0;
	int         rast_major = 0;
	int         rast_minor = 0;
	bit         rast_active = 1'b0;

	pixel_t pixel_q [$];
	int     mismatches = 0;
	int     work_items = 0;
	int     req_count = 0;
	int     load_count = 0;
	int     pixels_checked = 0;
	int     thick_seen = 0;
	int     ends_seen = 0;
	int     idle_cycles = 0;
	bit     send_calm = 1'b0;
	int     ready_hold = 0;
	int     ready_calm = 0;

	line_rasterizer_step #(.COORD_BITS(COORD_BITS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// gap length: mostly none, some short, a few long
	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// midpoint rasterizer: a load sets up the line, a step returns its next pixel
	function automatic bit rast_apply(input logic mode, input logic [IN_BITS-1:0] data,
			output pixel_t pix);
		int sx, sy, ex, ey, ax, ay, bx, by, dx, dy, t, px, py, sxp, syp, ty;
		bit last;
		pix = '0;
		if (mode == MODE_LOAD) begin
			sx = int'(data[9:0]);
			sy = int'(data[19:10]);
			ex = int'(data[29:20]);
			ey = int'(data[39:30]);
			// reflect into the first quadrant
			if (ex <= sx && ey >= sy) begin
				rast_oct = OCT_NEG_X;
				ax = -sx; ay = sy; bx = -ex; by = ey;
			end else if (ex <= sx && ey <= sy) begin
				rast_oct = OCT_REFLECT;
				ax = -sy; ay = -sx; bx = -ey; by = -ex;
			end else if (ex >= sx && sy >= ey) begin
				rast_oct = OCT_NEG_Y;
				ax = sx; ay = -sy; bx = ex; by = -ey;
			end else begin
				rast_oct = OCT_DIRECT;
				ax = sx; ay = sy; bx = ex; by = ey;
			end
			dy = by - ay;
			dx = bx - ax;
			rast_swapped = 1'b0;
			// steep line: walk along y instead
			if (dy > dx) begin
				rast_swapped = 1'b1;
				t = ax; ax = ay; ay = t;
				t = bx; bx = by; by = t;
				dy = by - ay;
				dx = bx - ax;
			end
			rast_decision = dy - (dx >> 1);
			rast_run = ax;
			rast_cross = ay;
			rast_run_end = bx;
			rast_major = dx;
			rast_minor = dy;
			rast_active = (ax < bx);
			return 1'b0;
		end
		if (!rast_active) return 1'b0;

		// advance one pixel along the run
		rast_run = rast_run + 1;
		if (rast_decision < 0) begin
			rast_decision = rast_decision + rast_minor;
		end else begin
			rast_decision = rast_decision + rast_minor - rast_major;
			rast_cross = rast_cross + 1;
		end
		px = rast_swapped ? rast_cross : rast_run;
		py = rast_swapped ? rast_run : rast_cross;

		// map back to screen space
		case (rast_oct)
			OCT_NEG_X: begin
				sxp = -px; syp = py; ty = py - 1;
			end
			OCT_REFLECT: begin
				sxp = -py; syp = -px; ty = -px - 1;
			end
			OCT_NEG_Y: begin
				sxp = px; syp = -py; ty = -py - 1;
			end
			default: begin
				sxp = px; syp = py; ty = py + 1;
			end
		endcase
		last = (rast_run >= rast_run_end);
		if (last) rast_active = 1'b0;

		pix.pixel_x = 10'(sxp);
		pix.pixel_y = 10'(syp);
		if (rast_width == LINE_WIDTH_THICK) begin
			pix.thick_valid = 1'b1;
			pix.thick_x = 10'(sxp);
			pix.thick_y = 12'(ty);
		end
		pix.last_pixel = last;
		return 1'b1;
	endfunction

	// random line: mostly short, some across the screen, some from the border
	function automatic logic [IN_BITS-1:0] pick_line();
		int sx, sy, ex, ey, r;
		r = $urandom_range(0, 99);
		sx = $urandom_range(0, COORD_MAX);
		sy = $urandom_range(0, COORD_MAX);
		if (r >= 90) begin
			if ($urandom_range(0, 1) == 1) sx = $urandom_range(0, 1) * COORD_MAX;
			else sy = $urandom_range(0, 1) * COORD_MAX;
		end
		if (r >= 80 && r < 90) begin
			ex = $urandom_range(0, COORD_MAX);
			ey = $urandom_range(0, COORD_MAX);
		end else begin
			ex = sx + int'($urandom_range(0, 24)) - 12;
			ey = sy + int'($urandom_range(0, 24)) - 12;
			ex = (ex < 0) ? 0 : ((ex > COORD_MAX) ? COORD_MAX : ex);
			ey = (ey < 0) ? 0 : ((ey > COORD_MAX) ? COORD_MAX : ey);
		end
		// horizontal, vertical and single-point lines
		r = $urandom_range(0, 15);
		if (r == 0) begin
			ey = sy;
		end else if (r == 1) begin
			ex = sx;
		end else if (r == 2) begin
			ex = sx;
			ey = sy;
		end
		return {10'(ey), 10'(ex), 10'(sy), 10'(sx)};
	endfunction

	function automatic void check_field(input string name, input logic [11:0] want,
			input logic [11:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// drive one request, wait for acceptance, then record what it should produce
	task automatic send_req(input logic mode, input logic [IN_BITS-1:0] data,
			input bit use_typed = 1'b0, input bit typed_has = 1'b0,
			input pixel_t typed_pix = '0);
		pixel_t pix;
		bit produced;
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		produced = rast_apply(mode, data, pix);
		if (use_typed) begin
			produced = typed_has;
			pix = typed_pix;
		end
		if (produced) pixel_q.push_back(pix);
		if (mode == MODE_LOAD || produced) work_items++;
		if (mode == MODE_LOAD) load_count++;
		req_count++;
		gap = send_calm ? 0 : gap_cycles();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic read_line_width(output logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= WIDTH_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		value = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// drain the block, write the width register and read it back
	task automatic set_line_width(input logic [1:0] value);
		logic [31:0] readback;
		s_tvalid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= WIDTH_ADDR;
		pwdata <= {30'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		rast_width = value;
		@(posedge clk);
		read_line_width(readback);
		if (readback !== {30'd0, value}) begin
			$display("%0t: line_width readback mismatch, expected %0h, actual %0h",
				$time, value, readback);
			mismatches++;
		end
	endtask

	// random phase: mostly whole lines, some cut short or overrun, plus noise
	task automatic run_phase(input int budget);
		int target, r, n, steps;
		target = work_items + budget;
		while (work_items < target) begin
			send_calm = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 99);
			if (r < 10) begin
				send_req(1'($urandom_range(0, 1)), IN_BITS'({$urandom, $urandom}));
			end else begin
				send_req(MODE_LOAD, pick_line());
				n = rast_active ? rast_run_end - rast_run : 0;
				r = $urandom_range(0, 99);
				// long lines are only walked part of the way
				if (n > 40) steps = $urandom_range(1, 40);
				else if (r < 75) steps = n;
				else if (r < 88) steps = n + $urandom_range(1, 3);
				else steps = $urandom_range(0, n);
				repeat (steps) send_req(MODE_STEP, IN_BITS'({$urandom, $urandom}));
			end
		end
	endtask

	// pixel sink with random stalls and calm stretches
	always @(posedge clk) begin : pixel_sink
		int hold;
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (ready_calm > 0) begin
			m_tready <= 1'b1;
			ready_calm <= ready_calm - 1;
		end else if ($urandom_range(0, 9) == 0) begin
			m_tready <= 1'b1;
			ready_calm <= $urandom_range(20, 80);
		end else begin
			hold = gap_cycles();
			m_tready <= (hold == 0);
			ready_hold <= (hold > 0) ? hold - 1 : 0;
		end
	end

	// compare each accepted pixel with the oldest expected one
	always @(posedge clk) begin : pixel_check
		pixel_t want;
		pixel_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[9:0], m_tdata[19:10], m_tuser, m_tdata[29:20], m_tdata[41:30],
				m_tlast};
			if (pixel_q.size() == 0) begin
				$display("%0t: unexpected pixel, actual x %0h y %0h", $time,
					got.pixel_x, got.pixel_y);
				mismatches++;
			end else begin
				want = pixel_q.pop_front();
				check_field("pixel_x", 12'(want.pixel_x), 12'(got.pixel_x));
				check_field("pixel_y", 12'(want.pixel_y), 12'(got.pixel_y));
				check_field("thick_valid", 12'(want.thick_valid), 12'(got.thick_valid));
				check_field("thick_x", 12'(want.thick_x), 12'(got.thick_x));
				check_field("thick_y", want.thick_y, got.thick_y);
				check_field("last_pixel", 12'(want.last_pixel), 12'(got.last_pixel));
				pixels_checked++;
				if (got.thick_valid) thick_seen++;
				if (got.last_pixel) ends_seen++;
			end
		end
	end

	// watchdog on cycles with no transfer on any port
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
				$display("line_rasterizer_step verification failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [31:0] readback;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// width register comes out of reset at one
		read_line_width(readback);
		if (readback !== {30'd0, LINE_WIDTH_RESET}) begin
			$display("%0t: line_width reset mismatch, expected %0h, actual %0h",
				$time, LINE_WIDTH_RESET, readback);
			mismatches++;
		end

		// directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIR_TABLE[i].cfg) set_line_width(DIR_TABLE[i].width);
			send_calm = ($urandom_range(0, 2) == 0);
			send_req(DIR_TABLE[i].mode,
				{DIR_TABLE[i].ey, DIR_TABLE[i].ex, DIR_TABLE[i].sy, DIR_TABLE[i].sx},
				DIR_TABLE[i].typed, DIR_TABLE[i].has_pix, DIR_TABLE[i].pix);
		end

		// random phases, one width setting each
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_line_width(PHASE_WIDTHS[p]);
			run_phase(PHASE_ITEMS);
		end

		// let the last pixels come out
		s_tvalid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("ran %0d requests, %0d of them line loads, across line widths 0 to 3",
			req_count, load_count);
		$display("checked %0d pixels, %0d with a thick neighbor, %0d line ends",
			pixels_checked, thick_seen, ends_seen);
		if (mismatches == 0) begin
			$display("line_rasterizer_step verification clean");
		end else begin
			$display("line_rasterizer_step verification failed");
		end
		$finish;
	end

endmodule
